FILE: rtl/acfs_pkg.sv
// shared types, constants and aes helper functions for the cbc sample encryptor
`timescale 1ns / 1ps
package acfs_pkg;

    localparam int FRAME_SIZE_BITS_DEF = 24;
    localparam int BLK_BYTES = 16;
    localparam int NUM_ROUNDS = 10;
    localparam int CFG_ADDR_BITS = 5;
    localparam logic [3:0] TRAILER_MASK = 4'hf;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW = 2'd1;
    localparam logic [1:0] REG_IV_HIGH = 2'd2;
    localparam logic [1:0] REG_IV_LOW = 2'd3;

    // item handed from the front part to the back part
    typedef struct packed {
        logic         is_block;
        logic         is_first;
        logic         last;
        logic [127:0] block;
        logic [7:0]   clear_byte;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } t_back_state;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit word, byte 0 most significant
    function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
        return w[127 - 8*i -: 8];
    endfunction

    // next round key from the current one
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // one round: subbytes, shiftrows, optional mixcolumns, add round key
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic do_mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[c*4+i] = sbox(byte_at(s, ((c + i) & 3) * 4 + i));
            end
        end
        if (do_mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/acfs_stream_if.sv
// valid/ready stream interface carrying a generic payload
`timescale 1ns / 1ps
interface acfs_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/acfs_front.sv
// front part: tracks sample position, gathers blocks and classifies bytes
`timescale 1ns / 1ps
module acfs_front #(
    parameter int FRAME_SIZE_BITS = acfs_pkg::FRAME_SIZE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic [23:0]                i_frame_size,
    output logic                       o_job_valid,
    input  logic                       i_job_ready,
    output acfs_pkg::t_job             o_job
);
    import acfs_pkg::*;

    localparam int LenW = (FRAME_SIZE_BITS > 24) ? 24 : FRAME_SIZE_BITS;

    logic [23:0]  r_bytes_left, n_bytes_left;
    logic [3:0]   r_trailer, n_trailer;
    logic [3:0]   r_gather_cnt, n_gather_cnt;
    logic [119:0] r_gather;
    logic         r_first_blk, n_first_blk;
    logic         r_out_valid;
    t_job         r_out, n_out;
    logic         fire, new_sample, emit;
    logic [23:0]  len, left;
    logic [3:0]   trl;

    assign o_ready = !r_out_valid || i_job_ready;
    assign fire    = i_valid && o_ready;
    assign new_sample = (r_bytes_left == 24'd0);

    always_comb begin
        len = 24'(i_frame_size[LenW-1:0]);
        if (len == 24'd0) begin
            len = 24'd1;
        end
        left = new_sample ? len : r_bytes_left;
        trl  = new_sample ? (len[3:0] & TRAILER_MASK) : r_trailer;
        n_bytes_left = left - 24'd1;
        n_trailer = trl;
        n_gather_cnt = new_sample ? 4'd0 : r_gather_cnt;
        n_first_blk = new_sample ? 1'b1 : r_first_blk;
        emit = 1'b0;
        n_out = r_out;
        n_out.is_first = n_first_blk;
        n_out.last = (n_bytes_left == 24'd0);
        n_out.clear_byte = i_data_byte;
        if (left > 24'(trl)) begin
            n_out.is_block = 1'b1;
            n_out.block = {r_gather, i_data_byte};
            if (n_gather_cnt == 4'd15) begin
                emit = 1'b1;
                n_first_blk = 1'b0;
            end
            n_gather_cnt = n_gather_cnt + 4'd1;
        end else begin
            n_out.is_block = 1'b0;
            emit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_trailer <= '0;
            r_gather_cnt <= '0;
            r_first_blk <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_bytes_left <= n_bytes_left;
                r_trailer <= n_trailer;
                r_gather_cnt <= n_gather_cnt;
                r_first_blk <= n_first_blk;
                r_out_valid <= emit;
            end else if (i_job_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_gather <= {r_gather[111:0], i_data_byte};
            if (emit) begin
                r_out <= n_out;
            end
        end
    end

    assign o_job_valid = r_out_valid;
    assign o_job = r_out;

    a_gather_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left == 24'd0) |-> (r_gather_cnt == 4'd0))
        else $error("gather count left over at sample end");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_job_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("job dropped under stall");
    a_nodouble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_trailer != 4'd0 && r_bytes_left != 24'd0 && r_bytes_left <= 24'(r_trailer))
        |-> (r_gather_cnt == 4'd0))
        else $error("partial block before trailer");
endmodule

FILE: rtl/acfs_back.sv
// back part: job queue, iterated aes round unit and byte serializer
`timescale 1ns / 1ps
module acfs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  acfs_pkg::t_job   i_job,
    input  logic [127:0]     i_key,
    input  logic [127:0]     i_iv,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_encrypted,
    output logic             o_sample_end
);
    import acfs_pkg::*;

    // two-entry queue between front and back
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        q_push, q_pop;
    t_job        q_head;

    t_back_state r_st, n_st;
    logic [127:0] r_state, r_rk, r_chain;
    logic [3:0]  r_round;
    logic        r_last;
    // output register: one finished block or one clear byte being sent
    logic        r_ob_valid;
    logic        r_ob_blk;
    logic        r_ob_last;
    logic [127:0] r_ob_data;
    logic [7:0]  r_ob_clear;
    logic [3:0]  r_idx;
    logic        start, clear_go, round_step, hand_off, ob_done, ob_free, emit_step;
    logic [127:0] rk_next;

    assign q_head = r_q[r_rp];
    assign o_job_ready = (r_cnt != 2'd2);
    assign q_push = i_job_valid && o_job_ready;
    assign q_pop = start || clear_go;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (r_cnt != 2'd0 && q_head.is_block) begin
                    n_st = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == 4'(NUM_ROUNDS)) begin
                    n_st = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (ob_free) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ob_done = r_ob_valid && i_ready && (!r_ob_blk || r_idx == 4'd15);
        ob_free = !r_ob_valid || ob_done;
        start = (r_st == ST_IDLE) && (r_cnt != 2'd0) && q_head.is_block;
        // clear bytes skip the round unit once it holds nothing older
        clear_go = (r_st == ST_IDLE) && (r_cnt != 2'd0) && !q_head.is_block && ob_free;
        round_step = (r_st == ST_ROUND);
        hand_off = (r_st == ST_EMIT) && ob_free;
        emit_step = r_ob_valid && i_ready;
        o_valid = r_ob_valid;
        o_out_byte = r_ob_blk ? byte_at(r_ob_data, int'(r_idx)) : r_ob_clear;
        o_encrypted = r_ob_blk;
        o_sample_end = r_ob_last && (!r_ob_blk || r_idx == 4'd15);
    end

    assign rk_next = key_next(r_rk, rcon(r_round));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
            r_ob_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (q_push) begin
                r_wp <= !r_wp;
            end
            if (q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(q_push) - 2'(q_pop);
            if (hand_off || clear_go) begin
                r_ob_valid <= 1'b1;
            end else if (ob_done) begin
                r_ob_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wp] <= i_job;
        end
        if (start) begin
            r_last <= q_head.last;
            r_round <= 4'd1;
            r_rk <= i_key;
            r_state <= q_head.block ^ (q_head.is_first ? i_iv : r_chain) ^ i_key;
        end else if (round_step) begin
            r_state <= aes_round(r_state, rk_next, r_round != 4'(NUM_ROUNDS));
            r_rk <= rk_next;
            r_round <= r_round + 4'd1;
            if (r_round == 4'(NUM_ROUNDS)) begin
                r_chain <= aes_round(r_state, rk_next, 1'b0);
            end
        end
        if (hand_off) begin
            r_ob_blk <= 1'b1;
            r_ob_last <= r_last;
            r_ob_data <= r_state;
            r_idx <= '0;
        end else if (clear_go) begin
            r_ob_blk <= 1'b0;
            r_ob_last <= q_head.last;
            r_ob_clear <= q_head.clear_byte;
            r_idx <= '0;
        end else if (emit_step) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    a_qcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue overflow");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_ROUND && r_round == 4'(NUM_ROUNDS)) |=> (r_st == ST_EMIT))
        else $error("round count out of step");
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hand_off |=> (r_st == ST_IDLE && r_ob_valid && r_ob_blk))
        else $error("block not moved to output register");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_valid && !i_ready) |=> (r_ob_valid && $stable(r_idx) && $stable(r_ob_blk)))
        else $error("output changed under stall");
endmodule

FILE: rtl/aes_cbc_full_sample_encryptor.sv
// top level: aes-128-cbc full sample encryptor with apb configuration
`timescale 1ns / 1ps
// Usage:
// in_ch carries one sample byte per transfer with the sample length; the
// length is taken on the first byte of each sample. out_ch gives one byte per
// transfer, flagged encrypted or clear, with sample_end on the last byte.
// The apb port writes key_high, key_low, iv_high, iv_low at 8*i (64-bit data).
// Input bytes are taken one per cycle while the queue has room; a queue of two
// jobs sits between the gathering front and the aes back end. A completed block
// is loaded from the queue, passes the iterated round unit (one round per cycle)
// and then moves to the output register; its 16 bytes then leave one per cycle
// while the receiver is ready. A clear trailer byte passes the front's output
// register and the queue into the output register once the output is free.
// The round unit runs while the previous block drains, so blocks stream at one
// byte per cycle while the receiver is ready; trailer bytes wait behind their
// sample's last block, so input can stall there.
// Reset clears the sample position, empties the queue and zeroes the key and iv registers.
// When the receiver stalls, the back end holds, the queue fills and in_ch
// ready falls; nothing is lost.
module aes_cbc_full_sample_encryptor #(
    parameter int FRAME_SIZE_BITS = acfs_pkg::FRAME_SIZE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    acfs_stream_if.sink                        in_ch,
    acfs_stream_if.source                      out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acfs_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);
    import acfs_pkg::*;

    logic [63:0] r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic        wr;
    logic [1:0]  reg_idx;
    logic        job_valid, job_ready;
    t_job        job;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low <= '0;
            r_iv_high <= '0;
            r_iv_low <= '0;
        end else if (wr && paddr[2:0] == 3'd0) begin
            case (reg_idx)
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LOW: r_key_low <= pwdata;
                REG_IV_HIGH: r_iv_high <= pwdata;
                REG_IV_LOW: r_iv_low <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LOW: prdata = r_key_low;
            REG_IV_HIGH: prdata = r_iv_high;
            REG_IV_LOW: prdata = r_iv_low;
            default: prdata = '0;
        endcase
    end

    acfs_front #(.FRAME_SIZE_BITS(FRAME_SIZE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_ch.valid), .o_ready(in_ch.ready),
        .i_data_byte(in_ch.data.data_byte), .i_frame_size(in_ch.data.frame_size),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    acfs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .i_key({r_key_high, r_key_low}), .i_iv({r_iv_high, r_iv_low}),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_out_byte(out_ch.data.out_byte), .o_encrypted(out_ch.data.encrypted),
        .o_sample_end(out_ch.data.sample_end)
    );
endmodule
